// ----- rtl/icc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types and constants of the input change coalescer.
// ----------------------------------------------------------------------------
package icc_pkg;

  localparam int CH_W    = 6;
  localparam int VALUE_W = 8;
  localparam int LINE_W  = 8;
  localparam int UNI_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [UNI_W-1:0] WILDCARD_UNIVERSE = 16'hFFFF;

  localparam logic REQ_VALUE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic REG_LINE     = 1'b0;
  localparam logic REG_UNIVERSE = 1'b1;

  typedef struct packed {
    logic [LINE_W-1:0] own_line;
    logic [UNI_W-1:0]  own_universe;
  } cfg_t;

  typedef struct packed {
    logic               present;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_RMW      = 6'b000100,
    ST_FL_READ  = 6'b001000,
    ST_FL_CHECK = 6'b010000,
    ST_FL_END   = 6'b100000
  } state_t;

endpackage

// ----- rtl/icc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/icc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_cfg
// Configuration registers behind the register port.
// ----------------------------------------------------------------------------
module icc_cfg
  import icc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_sel;
  logic wr_fire;

  assign reg_sel = paddr[2];
  assign wr_fire = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_fire) begin
      unique case (reg_sel)
        REG_LINE:     cfg.own_line     <= pwdata[LINE_W-1:0];
        REG_UNIVERSE: cfg.own_universe <= pwdata[UNI_W-1:0];
        default:      cfg              <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LINE:     prdata = DATA_W'(cfg.own_line);
      REG_UNIVERSE: prdata = DATA_W'(cfg.own_universe);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- rtl/icc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_ctrl
// Read-modify-write sequencer over the channel store, flush walker and
// result register.
// ----------------------------------------------------------------------------
module icc_ctrl
  import icc_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               evt_valid,
  output logic               evt_ready,
  input  logic               req_type,
  input  logic [UNI_W-1:0]   event_universe,
  input  logic [LINE_W-1:0]  event_line,
  input  logic [CH_W-1:0]    channel_index,
  input  logic [VALUE_W-1:0] channel_value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [CH_W-1:0]    out_channel,
  output logic [VALUE_W-1:0] out_value,
  output logic               last_of_run
);

  localparam int AW = $clog2(CHANNELS);
  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

  state_t             state, state_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW-1:0]      ch_q;
  logic [VALUE_W-1:0] val_q;
  logic               pend_valid, pend_valid_next;
  logic [AW-1:0]      pend_ch, pend_ch_next;
  logic [VALUE_W-1:0] pend_val, pend_val_next;
  logic               res_valid_next;
  logic [CH_W-1:0]    out_channel_next;
  logic [VALUE_W-1:0] out_value_next;
  logic               last_of_run_next;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  logic out_free;
  logic uni_match;
  logic accept;

  assign out_free  = !res_valid || res_ready;
  assign uni_match = (event_universe == WILDCARD_UNIVERSE) ||
                     (event_universe == cfg.own_universe);
  assign accept    = evt_valid && evt_ready;

  icc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    pend_valid_next  = pend_valid;
    pend_ch_next     = pend_ch;
    pend_val_next    = pend_val;
    res_valid_next   = res_valid && !res_ready;
    out_channel_next = out_channel;
    out_value_next   = out_value;
    last_of_run_next = last_of_run;
    evt_ready        = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = idx;
    wr_en            = 1'b0;
    wr_addr          = idx;
    wr_data          = '0;

    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        evt_ready = 1'b1;
        rd_addr   = AW'(channel_index);
        rd_en     = evt_valid;
        if (evt_valid && uni_match) begin
          if (req_type == REQ_FLUSH) begin
            idx_next        = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_FL_READ;
          end else if (event_line == cfg.own_line &&
                       32'(channel_index) < CHANNELS) begin
            state_next = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        wr_addr = ch_q;
        wr_data = '{present: 1'b1, value: val_q};
        if (!rd_data.present) begin
          wr_en      = 1'b1;
          state_next = ST_IDLE;
        end else if (rd_data.value != val_q) begin
          if (rd_data.value == '0 || val_q == '0) begin
            if (out_free) begin
              wr_en            = 1'b1;
              res_valid_next   = 1'b1;
              out_channel_next = CH_W'(ch_q);
              out_value_next   = rd_data.value;
              last_of_run_next = 1'b1;
              state_next       = ST_IDLE;
            end
          end else begin
            wr_en      = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_READ: begin
        rd_en      = 1'b1;
        state_next = ST_FL_CHECK;
      end
      ST_FL_CHECK: begin
        if (!(rd_data.present && pend_valid && !out_free)) begin
          wr_en = 1'b1;
          if (rd_data.present) begin
            if (pend_valid) begin
              res_valid_next   = 1'b1;
              out_channel_next = CH_W'(pend_ch);
              out_value_next   = pend_val;
              last_of_run_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_ch_next    = idx;
            pend_val_next   = rd_data.value;
          end
          if (idx == LAST_IDX) begin
            state_next = ST_FL_END;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_FL_READ;
          end
        end
      end
      ST_FL_END: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          res_valid_next   = 1'b1;
          out_channel_next = CH_W'(pend_ch);
          out_value_next   = pend_val;
          last_of_run_next = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q  <= AW'(channel_index);
      val_q <= channel_value;
    end
    pend_ch     <= pend_ch_next;
    pend_val    <= pend_val_next;
    out_channel <= out_channel_next;
    out_value   <= out_value_next;
    last_of_run <= last_of_run_next;
  end

`ifndef NO_ASSERTIONS
  a_rmw_single_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW && state_next == ST_IDLE && res_valid_next && out_free)
      |=> last_of_run)
    else $error("value event result not marked as last");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("flush left a pending entry behind");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(idx) < CHANNELS)
    else $error("walk index beyond the store");

  a_walk_writes_zero: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != ST_RMW) |-> (wr_data == '0))
    else $error("clear or flush wrote a nonzero entry");
`endif

endmodule

// ----- rtl/input_change_coalescer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_change_coalescer
// Per-channel coalescing of controller input values with flush.
// ----------------------------------------------------------------------------
// Items arrive on the evt_valid/evt_ready channel; a value event updates one
// channel entry, a flush drains the whole store. Results leave on the
// res_valid/res_ready channel through a single result register, so the next
// item is taken while an earlier result still waits to be collected.
// In the accept cycle of a value event the store entry is read; ST_RMW then
// compares and writes it back, placing any result in the output register and
// holding while that register is full. An event that does not match the
// configured line or universe is dropped in its accept cycle.
// A flush walks the store entry by entry through ST_FL_READ and ST_FL_CHECK,
// zeroing each entry as it passes; results come out in ascending channel
// order with the final one marked by last_of_run.
// If the receiver stalls, the sequencer holds where it needs the result
// register and resumes once it empties. After reset the store is cleared one
// entry per cycle, during which no item is accepted; register writes are
// taken at any time.
// ----------------------------------------------------------------------------
module input_change_coalescer
  import icc_pkg::*;
#(
  parameter int CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               evt_valid,
  output logic               evt_ready,
  input  logic               req_type,
  input  logic [UNI_W-1:0]   event_universe,
  input  logic [LINE_W-1:0]  event_line,
  input  logic [CH_W-1:0]    channel_index,
  input  logic [VALUE_W-1:0] channel_value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [CH_W-1:0]    out_channel,
  output logic [VALUE_W-1:0] out_value,
  output logic               last_of_run
);

  cfg_t cfg;

  icc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  icc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .evt_valid      (evt_valid),
    .evt_ready      (evt_ready),
    .req_type       (req_type),
    .event_universe (event_universe),
    .event_line     (event_line),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .out_channel    (out_channel),
    .out_value      (out_value),
    .last_of_run    (last_of_run)
  );

endmodule

// ----- verif/input_change_coalescer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_change_coalescer_tb
// Self-checking testbench of the input change coalescer.
// ----------------------------------------------------------------------------
// A table of directed items covers the store's empty, silent, changed, equal
// and mismatched cases and the flush, with single results typed in where
// they are obvious. Random phases follow under several line and universe
// settings, with random idling on both sides, one long receiver hold-off and
// one phase without any idling. Every result is checked in order against the
// typed result or a local model of the per-channel store.
// ----------------------------------------------------------------------------
module input_change_coalescer_tb;
  import icc_pkg::*;

  localparam int CHANNELS        = 64;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int SETTLE_CYCLES   = 4 * CHANNELS;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] value;
    logic               last;
  } emit_t;

  typedef enum logic [2:0] {
    ROW_MODEL,
    ROW_NONE,
    ROW_ONE,
    ROW_CFG_LINE,
    ROW_CFG_UNI
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               req;
    logic [UNI_W-1:0]   uni;
    logic [LINE_W-1:0]  line;
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] value;
    emit_t              typed;
  } row_t;

  localparam emit_t NO_EMIT = '0;

  localparam row_t DIRECTED [24] = '{
    '{ROW_NONE,     REQ_FLUSH, 16'h0000, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_ONE,      REQ_VALUE, 16'h0000, 8'd0,   6'd0,  8'd255, '{6'd0, 8'd0, 1'b1}},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd0,   6'd0,  8'd255, NO_EMIT},
    '{ROW_ONE,      REQ_VALUE, 16'h0000, 8'd0,   6'd0,  8'd0,   '{6'd0, 8'd255, 1'b1}},
    '{ROW_NONE,     REQ_VALUE, 16'hFFFF, 8'd0,   6'd63, 8'd255, NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd0,   6'd63, 8'd170, NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd255, 6'd63, 8'd0,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'h0001, 8'd0,   6'd63, 8'd0,   NO_EMIT},
    '{ROW_ONE,      REQ_VALUE, 16'hFFFF, 8'd0,   6'd63, 8'd0,   '{6'd63, 8'd170, 1'b1}},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd0,   6'd5,  8'd85,  NO_EMIT},
    '{ROW_NONE,     REQ_FLUSH, 16'h0001, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_MODEL,    REQ_FLUSH, 16'hFFFF, 8'd255, 6'd63, 8'd255, NO_EMIT},
    '{ROW_NONE,     REQ_FLUSH, 16'h0000, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_CFG_LINE, REQ_VALUE, 16'h00FF, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_CFG_UNI,  REQ_VALUE, 16'hFFFE, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'hFFFE, 8'd255, 6'd1,  8'd1,   NO_EMIT},
    '{ROW_ONE,      REQ_VALUE, 16'hFFFE, 8'd255, 6'd1,  8'd0,   '{6'd1, 8'd1, 1'b1}},
    '{ROW_NONE,     REQ_VALUE, 16'h0000, 8'd255, 6'd1,  8'd7,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'hFFFE, 8'd0,   6'd1,  8'd7,   NO_EMIT},
    '{ROW_CFG_UNI,  REQ_VALUE, 16'hFFFF, 8'd0,   6'd0,  8'd0,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'hFFFF, 8'd255, 6'd2,  8'd9,   NO_EMIT},
    '{ROW_NONE,     REQ_VALUE, 16'hFFFE, 8'd255, 6'd2,  8'd0,   NO_EMIT},
    '{ROW_MODEL,    REQ_FLUSH, 16'hFFFF, 8'd0,   6'd0,  8'd0,   NO_EMIT}
  };

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [ADDR_W-1:0]  paddr          = '0;
  logic [DATA_W-1:0]  pwdata         = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               evt_valid      = 1'b0;
  logic               evt_ready;
  logic               req_type       = REQ_VALUE;
  logic [UNI_W-1:0]   event_universe = '0;
  logic [LINE_W-1:0]  event_line     = '0;
  logic [CH_W-1:0]    channel_index  = '0;
  logic [VALUE_W-1:0] channel_value  = '0;
  logic               res_valid;
  logic               res_ready      = 1'b0;
  logic [CH_W-1:0]    out_channel;
  logic [VALUE_W-1:0] out_value;
  logic               last_of_run;

  row_kind_t item_kind  = ROW_MODEL;
  emit_t     item_typed = '0;

  logic idle_on   = 1'b1;
  logic stall_on  = 1'b1;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  logic [VALUE_W-1:0] saved [CHANNELS] = '{default: '0};
  logic               held  [CHANNELS] = '{default: 1'b0};
  logic [LINE_W-1:0]  own_line_m = '0;
  logic [UNI_W-1:0]   own_uni_m  = '0;

  emit_t new_emits [$];
  emit_t pending_emits [$];

  int          mismatch_count   = 0;
  int          items_taken      = 0;
  int          flushes_taken    = 0;
  int          results_seen     = 0;
  int          settings_written = 0;
  int unsigned cycle_count      = 0;

  input_change_coalescer #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .evt_valid     (evt_valid),
    .evt_ready     (evt_ready),
    .req_type      (req_type),
    .event_universe(event_universe),
    .event_line    (event_line),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_channel   (out_channel),
    .out_value     (out_value),
    .last_of_run   (last_of_run)
  );

  always #4 clk = ~clk;

  function automatic logic universe_ok(input logic [UNI_W-1:0] uni);
    return uni == WILDCARD_UNIVERSE || uni == own_uni_m;
  endfunction

  function automatic void coalesce(input logic req, input logic [UNI_W-1:0] uni,
                                   input logic [LINE_W-1:0] line, input logic [CH_W-1:0] ch,
                                   input logic [VALUE_W-1:0] value);
    int                 last_ch;
    logic [VALUE_W-1:0] old;
    new_emits.delete();
    if (req == REQ_FLUSH) begin
      if (!universe_ok(uni)) return;
      last_ch = -1;
      for (int i = 0; i < CHANNELS; i++) if (held[i]) last_ch = i;
      for (int i = 0; i < CHANNELS; i++) begin
        if (held[i]) new_emits.push_back('{CH_W'(i), saved[i], i == last_ch});
        held[i]  = 1'b0;
        saved[i] = '0;
      end
      return;
    end
    if (line != own_line_m || !universe_ok(uni)) return;
    if (int'(ch) >= CHANNELS) return;
    if (!held[ch]) begin
      held[ch]  = 1'b1;
      saved[ch] = value;
      return;
    end
    if (saved[ch] != value) begin
      old = saved[ch];
      if (old == '0 || value == '0) new_emits.push_back('{ch, old, 1'b1});
      saved[ch] = value;
    end
  endfunction

  function automatic row_t random_item(input logic [LINE_W-1:0] line_cfg,
                                       input logic [UNI_W-1:0] uni_cfg,
                                       input logic [CH_W-1:0] ch_base);
    row_t r;
    int   roll;
    r      = '0;
    r.kind = ROW_MODEL;
    r.req  = REQ_VALUE;
    r.uni  = ($urandom_range(3) == 0) ? WILDCARD_UNIVERSE : uni_cfg;
    r.line = line_cfg;
    if ($urandom_range(3) == 0) r.ch = CH_W'($urandom_range(63));
    else r.ch = ch_base + CH_W'($urandom_range(7));
    roll = $urandom_range(99);
    if (roll < 35) r.value = '0;
    else if (roll < 45) r.value = '1;
    else r.value = VALUE_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 7) begin
      r.req   = REQ_FLUSH;
      r.line  = LINE_W'($urandom);
      r.value = VALUE_W'($urandom);
      if ($urandom_range(3) == 0) r.uni = UNI_W'($urandom);
    end else if (roll < 17) begin
      if ($urandom_range(1) == 0) r.line = LINE_W'($urandom);
      else r.uni = UNI_W'($urandom);
    end
    return r;
  endfunction

  task automatic offer(input row_t r);
    while (idle_on && $urandom_range(99) < 16) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid      <= 1'b1;
    req_type       <= r.req;
    event_universe <= r.uni;
    event_line     <= r.line;
    channel_index  <= r.ch;
    channel_value  <= r.value;
    item_kind      <= r.kind;
    item_typed     <= r.typed;
    do @(posedge clk); while (!(evt_valid && evt_ready));
  endtask

  task automatic wait_idle();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (pending_emits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic reg_sel, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * reg_sel);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_LINE) own_line_m = data[LINE_W-1:0];
    else own_uni_m = data[UNI_W-1:0];
    settings_written++;
  endtask

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= !stall_on || $urandom_range(99) >= 16;
    end
  end

  always @(posedge clk) begin : watch
    emit_t want;
    if (!rst && evt_valid && evt_ready) begin
      coalesce(req_type, event_universe, event_line, channel_index, channel_value);
      items_taken++;
      if (req_type == REQ_FLUSH) flushes_taken++;
      if (item_kind == ROW_ONE) pending_emits.push_back(item_typed);
      else if (item_kind == ROW_MODEL) foreach (new_emits[k]) pending_emits.push_back(new_emits[k]);
    end
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_emits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: channel %0d value %0d last %0b",
                   out_channel, out_value, last_of_run);
      end else begin
        want = pending_emits.pop_front();
        if (out_channel !== want.ch || out_value !== want.value || last_of_run !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected channel %0d value %0d last %0b, got %0d %0d %0b",
                     want.ch, want.value, want.last, out_channel, out_value, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_emits.size());
      $display("input_change_coalescer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [LINE_W-1:0] line_cfg;
    logic [UNI_W-1:0]  uni_cfg;
    logic [CH_W-1:0]   ch_base;
    int                leftover;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG_LINE || DIRECTED[r].kind == ROW_CFG_UNI) begin
        wait_idle();
        reg_write(DIRECTED[r].kind == ROW_CFG_LINE ? REG_LINE : REG_UNIVERSE,
                  DATA_W'(DIRECTED[r].uni));
      end else begin
        offer(DIRECTED[r]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        1: begin
          line_cfg = '1;
          uni_cfg  = 16'hFFFE;
        end
        2: begin
          line_cfg = '0;
          uni_cfg  = '0;
        end
        3: begin
          line_cfg = LINE_W'($urandom);
          uni_cfg  = WILDCARD_UNIVERSE;
        end
        default: begin
          line_cfg = LINE_W'($urandom);
          uni_cfg  = UNI_W'($urandom_range(16'hFFFE));
        end
      endcase
      reg_write(REG_LINE, DATA_W'(line_cfg));
      reg_write(REG_UNIVERSE, DATA_W'(uni_cfg));
      idle_on  = (p != 2);
      stall_on = (p != 2);
      if (p == 1) hold_go <= 1'b1;
      ch_base = CH_W'($urandom_range(63));
      repeat (ITEMS_PER_PHASE) offer(random_item(line_cfg, uni_cfg, ch_base));
    end

    wait_idle();
    leftover = pending_emits.size();
    $display("Ran %0d items including %0d flushes under %0d register writes.",
             items_taken, flushes_taken, settings_written);
    $display("Checked %0d results: %0d mismatches, %0d never delivered.",
             results_seen, mismatch_count, leftover);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("input_change_coalescer_tb: done, clean");
    end else begin
      $display("input_change_coalescer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- input_change_coalescer.f -----
rtl/icc_pkg.sv
rtl/icc_ram.sv
rtl/icc_cfg.sv
rtl/icc_ctrl.sv
rtl/input_change_coalescer.sv
verif/input_change_coalescer_tb.sv
